[rtl/core/tld_pkg.sv]
// Package for the tilt LED mode display core.
// Holds the mode and register codes, the state and result structs, and reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tld_pkg;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 16;

	typedef enum logic [1:0] {
		MODE_BAR    = 2'd0,
		MODE_BOUNCE = 2'd1,
		MODE_RIPPLE = 2'd2,
		MODE_BLINK  = 2'd3
	} tld_mode_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_LEVEL_ONE   = 3'd0,
		REG_LEVEL_TWO   = 3'd1,
		REG_LEVEL_THREE = 3'd2,
		REG_LEVEL_FOUR  = 3'd3,
		REG_SHAKE_DELTA = 3'd4,
		REG_HOLDOFF_MS  = 3'd5
	} tld_reg_t;

	typedef struct packed {
		logic [14:0] level_one;
		logic [14:0] level_two;
		logic [14:0] level_three;
		logic [14:0] level_four;
		logic [15:0] shake_delta;
		logic [15:0] shake_holdoff_ms;
	} tld_cfg_t;

	typedef struct packed {
		logic               primed;
		tld_mode_t          mode;
		logic signed [15:0] previous_z;
		logic [31:0]        last_shake_ms;
		logic [2:0]         chase_index;
		logic               chase_upward;
		logic [31:0]        last_chase_ms;
		logic [2:0]         wave_start;
		logic [31:0]        last_wave_ms;
		logic [31:0]        last_flash_ms;
		logic               flash_on;
		logic [7:0]         led_hold;
	} tld_state_t;

	typedef struct packed {
		logic [7:0] led_pattern;
		tld_mode_t  display_mode;
		logic       shake_seen;
	} tld_result_t;

	localparam logic [14:0] LEVEL_ONE_RESET   = 15'd2457;
	localparam logic [14:0] LEVEL_TWO_RESET   = 15'd4915;
	localparam logic [14:0] LEVEL_THREE_RESET = 15'd8192;
	localparam logic [14:0] LEVEL_FOUR_RESET  = 15'd11468;
	localparam logic [15:0] SHAKE_DELTA_RESET = 16'd9830;
	localparam logic [15:0] HOLDOFF_MS_RESET  = 16'd2000;

	localparam logic [2:0] CHASE_START = 3'd4;

endpackage : tld_pkg

`default_nettype wire

[rtl/core/tld_if.sv]
// Valid/ready channel interfaces for the tilt LED mode display core.
// Sample channel carries the sensor item, result channel carries the LED item.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface tld_sample_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] tilt_y;
	logic signed [15:0] accel_z;
	logic [31:0]        now_ms;

	modport source (output valid, output tilt_y, output accel_z, output now_ms, input ready);
	modport sink (input valid, input tilt_y, input accel_z, input now_ms, output ready);
endinterface : tld_sample_if

interface tld_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] led_pattern;
	logic [1:0] display_mode;
	logic       shake_seen;

	modport source (output valid, output led_pattern, output display_mode, output shake_seen,
		input ready);
	modport sink (input valid, input led_pattern, input display_mode, input shake_seen,
		output ready);
endinterface : tld_result_if

`default_nettype wire

[rtl/core/tld_step.sv]
// Next-state and result logic for one sensor item of the tilt LED mode display.
// Shake detection, speed levels and the four display modes; purely combinational.
// Depends on tld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tld_step (
	input  tld_pkg::tld_cfg_t    cfg,
	input  tld_pkg::tld_state_t  state,
	input  logic signed [15:0]   tilt_y,
	input  logic signed [15:0]   accel_z,
	input  logic [31:0]          now_ms,
	output tld_pkg::tld_state_t  state_next,
	output tld_pkg::tld_result_t result,
	output logic                 has_result
);
	import tld_pkg::*;

	localparam logic signed [16:0] DIR_COUNTS  = 17'sd1638;
	localparam logic signed [16:0] SIDE_COUNTS = 17'sd819;
	localparam logic [31:0]        WAVE_MS     = 32'd80;

	function automatic logic [31:0] chase_period(input logic [1:0] lvl);
		logic [31:0] p;
		unique case (lvl)
			2'd0: p = 32'd100;
			2'd1: p = 32'd70;
			2'd2: p = 32'd50;
			2'd3: p = 32'd30;
		endcase
		return p;
	endfunction

	function automatic logic [31:0] flash_period(input logic [1:0] lvl);
		logic [31:0] p;
		unique case (lvl)
			2'd0: p = 32'd500;
			2'd1: p = 32'd250;
			2'd2: p = 32'd150;
			2'd3: p = 32'd80;
		endcase
		return p;
	endfunction

	logic signed [16:0] dz;
	logic [16:0]        dz_mag;
	logic [31:0]        shake_elapsed;
	logic               shake;
	logic [15:0]        tilt_abs;
	logic [1:0]         lvl;
	logic signed [16:0] t17;
	logic signed [16:0] lv1, lv2, lv3, lv4;
	logic [7:0]         bar;
	logic               dir_up;
	logic [7:0]         wave_mask;
	logic [15:0]        wave_rot;

	assign dz            = {accel_z[15], accel_z} - {state.previous_z[15], state.previous_z};
	assign dz_mag        = dz[16] ? 17'(-dz) : 17'(dz);
	assign shake_elapsed = now_ms - state.last_shake_ms;
	assign shake         = state.primed && (shake_elapsed >= {16'd0, cfg.shake_holdoff_ms})
		&& (dz_mag > {1'b0, cfg.shake_delta});

	assign tilt_abs = tilt_y[15] ? 16'(-tilt_y) : 16'(tilt_y);
	always_comb begin
		if (tilt_abs > {1'b0, cfg.level_three}) begin
			lvl = 2'd3;
		end else if (tilt_abs > {1'b0, cfg.level_two}) begin
			lvl = 2'd2;
		end else if (tilt_abs > {1'b0, cfg.level_one}) begin
			lvl = 2'd1;
		end else begin
			lvl = 2'd0;
		end
	end

	assign t17 = {tilt_y[15], tilt_y};
	assign lv1 = {2'b00, cfg.level_one};
	assign lv2 = {2'b00, cfg.level_two};
	assign lv3 = {2'b00, cfg.level_three};
	assign lv4 = {2'b00, cfg.level_four};

	always_comb begin
		bar = 8'h00;
		if (t17 > lv1) begin
			bar[4] = 1'b1;
			bar[5] = t17 > lv2;
			bar[6] = t17 > lv3;
			bar[7] = t17 > lv4;
		end else if (t17 < -lv1) begin
			bar[3] = 1'b1;
			bar[2] = t17 < -lv2;
			bar[1] = t17 < -lv3;
			bar[0] = t17 < -lv4;
		end
	end

	assign wave_mask = {4'b0000, 4'b1111 >> (2'd3 - lvl)};

	always_comb begin
		state_next = state;
		result     = '0;
		has_result = 1'b0;
		dir_up     = state.chase_upward;
		wave_rot   = '0;
		if (!state.primed) begin
			state_next.primed        = 1'b1;
			state_next.previous_z    = accel_z;
			state_next.last_shake_ms = now_ms;
		end else begin
			has_result            = 1'b1;
			state_next.previous_z = accel_z;
			if (shake) begin
				state_next.last_shake_ms = now_ms;
				state_next.mode          = tld_mode_t'(state.mode + 2'd1);
				state_next.chase_index   = CHASE_START;
				state_next.wave_start    = 3'd0;
				state_next.flash_on      = 1'b0;
				state_next.led_hold      = 8'h00;
			end
			unique case (state_next.mode)
				MODE_BAR: begin
					state_next.led_hold = bar;
				end
				MODE_BOUNCE: begin
					if ((now_ms - state.last_chase_ms) > chase_period(lvl)) begin
						state_next.last_chase_ms = now_ms;
						if (t17 > DIR_COUNTS) begin
							dir_up = 1'b1;
						end else if (t17 < -DIR_COUNTS) begin
							dir_up = 1'b0;
						end
						if (dir_up) begin
							if (state_next.chase_index >= 3'd6) begin
								state_next.chase_index  = 3'd7;
								state_next.chase_upward = 1'b0;
							end else begin
								state_next.chase_index  = state_next.chase_index + 3'd1;
								state_next.chase_upward = 1'b1;
							end
						end else begin
							if (state_next.chase_index <= 3'd1) begin
								state_next.chase_index  = 3'd0;
								state_next.chase_upward = 1'b1;
							end else begin
								state_next.chase_index  = state_next.chase_index - 3'd1;
								state_next.chase_upward = 1'b0;
							end
						end
					end
					state_next.led_hold = 8'h01 << state_next.chase_index;
				end
				MODE_RIPPLE: begin
					if ((now_ms - state.last_wave_ms) > WAVE_MS) begin
						state_next.last_wave_ms = now_ms;
						state_next.wave_start   = state_next.wave_start + 3'd1;
					end
					wave_rot            = {wave_mask, wave_mask} << state_next.wave_start;
					state_next.led_hold = wave_rot[15:8];
				end
				MODE_BLINK: begin
					if ((now_ms - state.last_flash_ms) > flash_period(lvl)) begin
						state_next.last_flash_ms = now_ms;
						state_next.flash_on      = !state_next.flash_on;
						if (!state_next.flash_on) begin
							state_next.led_hold = 8'h00;
						end else if (t17 > SIDE_COUNTS) begin
							state_next.led_hold = 8'hF0;
						end else if (t17 < -SIDE_COUNTS) begin
							state_next.led_hold = 8'h0F;
						end else begin
							state_next.led_hold = 8'hFF;
						end
					end
				end
			endcase
			result.led_pattern  = state_next.led_hold;
			result.display_mode = state_next.mode;
			result.shake_seen   = shake;
		end
	end

endmodule : tld_step

`default_nettype wire

[rtl/core/tilt_led_mode_display_core.sv]
// Top level of the tilt LED mode display: input register, step logic, result register.
// Depends on tld_pkg, tld_sample_if, tld_result_if and tld_step.
//
// Channel   Dir  Handshake     Payload
// sample    in   valid/ready   tilt_y[15:0] s, accel_z[15:0] s, now_ms[31:0]
// result    out  valid/ready   led_pattern[7:0], display_mode[1:0], shake_seen
// cfg       in   cfg_we        cfg_index[2:0], cfg_data[15:0]
//
// One item per cycle while the result is not stalled; an item is held in the input register
// and its result is then registered in the result register.
// The first item after reset only primes the state and yields no result.
// A stalled result holds the result register and the input register; the input register
// still takes an item while it is empty.
// Reset is asynchronous; it restores the state, config and valid flags, not the data registers.
`timescale 1ns / 1ps
`default_nettype none

module tilt_led_mode_display_core (
	input  logic                                clk,
	input  logic                                arst_n,
	tld_sample_if.sink                          sample,
	tld_result_if.source                        result,
	input  logic                                cfg_we,
	input  logic [tld_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [tld_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import tld_pkg::*;

	tld_cfg_t           cfg_q;
	tld_state_t         state_q;
	tld_state_t         state_next;
	tld_result_t        step_result;
	logic               step_has_result;
	logic               valid_s1;
	logic signed [15:0] tilt_y_s1;
	logic signed [15:0] accel_z_s1;
	logic [31:0]        now_ms_s1;
	logic               out_valid_q;
	tld_result_t        out_data_q;
	logic               advance;

	assign advance      = valid_s1 && (!out_valid_q || result.ready);
	assign sample.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.level_one        <= LEVEL_ONE_RESET;
			cfg_q.level_two        <= LEVEL_TWO_RESET;
			cfg_q.level_three      <= LEVEL_THREE_RESET;
			cfg_q.level_four       <= LEVEL_FOUR_RESET;
			cfg_q.shake_delta      <= SHAKE_DELTA_RESET;
			cfg_q.shake_holdoff_ms <= HOLDOFF_MS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LEVEL_ONE:   cfg_q.level_one        <= cfg_data[14:0];
				REG_LEVEL_TWO:   cfg_q.level_two        <= cfg_data[14:0];
				REG_LEVEL_THREE: cfg_q.level_three      <= cfg_data[14:0];
				REG_LEVEL_FOUR:  cfg_q.level_four       <= cfg_data[14:0];
				REG_SHAKE_DELTA: cfg_q.shake_delta      <= cfg_data;
				REG_HOLDOFF_MS:  cfg_q.shake_holdoff_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			tilt_y_s1  <= sample.tilt_y;
			accel_z_s1 <= sample.accel_z;
			now_ms_s1  <= sample.now_ms;
		end
	end

	tld_step u_step (
		.cfg        (cfg_q),
		.state      (state_q),
		.tilt_y     (tilt_y_s1),
		.accel_z    (accel_z_s1),
		.now_ms     (now_ms_s1),
		.state_next (state_next),
		.result     (step_result),
		.has_result (step_has_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.primed        <= 1'b0;
			state_q.mode          <= MODE_BAR;
			state_q.previous_z    <= '0;
			state_q.last_shake_ms <= '0;
			state_q.chase_index   <= CHASE_START;
			state_q.chase_upward  <= 1'b1;
			state_q.last_chase_ms <= '0;
			state_q.wave_start    <= '0;
			state_q.last_wave_ms  <= '0;
			state_q.last_flash_ms <= '0;
			state_q.flash_on      <= 1'b0;
			state_q.led_hold      <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step_has_result;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_has_result) begin
			out_data_q <= step_result;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.led_pattern  = out_data_q.led_pattern;
	assign result.display_mode = out_data_q.display_mode;
	assign result.shake_seen   = out_data_q.shake_seen;

	// The priming item leaves the result register empty.
	a_prime_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !state_q.primed) |=> !result.valid)
		else $error("priming item produced a result");

	a_result_needs_prime: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> state_q.primed)
		else $error("result present before the state was primed");

	a_primed_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && state_q.primed) |=> result.valid)
		else $error("item after priming produced no result");

	a_empty_takes_item: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> sample.ready)
		else $error("empty input register refused an item");

endmodule : tilt_led_mode_display_core

`default_nettype wire
